// ===== rtl/http_response_chunked_deframer_macros.svh =====
// Assertion macros used by the deframer port checker.
`ifndef HTTP_RESPONSE_CHUNKED_DEFRAMER_MACROS_SVH
`define HTTP_RESPONSE_CHUNKED_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HRCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrcd check failed");

// Next-cycle implication, disabled while in reset.
`define HRCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrcd check failed");

`endif

// ===== rtl/hrcd_pkg.sv =====
// Types, constants and helper functions for the chunked response deframer.
package hrcd_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int MAX_W      = 24;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 2;
    localparam int TAIL_DEPTH = 26;
    localparam int OK_LEN     = 5;

    localparam logic [MAX_W-1:0]  MAX_BODY_RESET = 24'd8388608;
    localparam logic [ADDR_W-1:0] REG_MAX_BODY   = 2'd0;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_HDR_END  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_200     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHUNK_BAD   = 3'd4;

    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

    // first character sits in the top byte
    localparam logic [8*TAIL_DEPTH-1:0] TE_TEXT = "transfer-encoding: chunked";
    localparam logic [8*OK_LEN-1:0]     OK_TEXT = " 200 ";

    typedef struct packed {
        logic [BYTE_W-1:0] raw_byte;
        logic              end_of_response;
    } hrcd_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   body_byte;
        logic                body_valid;
        logic                done_res;
        logic [STATUS_W-1:0] status;
    } hrcd_result_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
            r = c + 8'h20;
        return r;
    endfunction

    // bit 4 set when c is a hex digit, low nibble its value
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        logic [4:0]        r;
        d = 8'h00;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/hrcd_in_if.sv =====
// Raw response byte channel.
interface hrcd_in_if import hrcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] raw_byte;
    logic              end_of_response;

    modport source (output valid, output raw_byte, output end_of_response, input ready);
    modport sink   (input valid, input raw_byte, input end_of_response, output ready);
endinterface

// ===== rtl/hrcd_out_if.sv =====
// Decoded body and status channel.
interface hrcd_out_if import hrcd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   body_byte;
    logic                body_valid;
    logic                done_res;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output body_byte, output body_valid, output done_res,
                    output status, input ready);
    modport sink   (input valid, input body_byte, input body_valid, input done_res,
                    input status, output ready);
endinterface

// ===== rtl/hrcd_apb_regs.sv =====
// APB register file holding the body length limit.
module hrcd_apb_regs import hrcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [MAX_W-1:0]  max_body_bytes
);

    logic [MAX_W-1:0] max_body_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_body_reg <= MAX_BODY_RESET;
        else if (wr_en)
            max_body_reg <= pwdata[MAX_W-1:0];
    end

    assign prdata = (paddr == REG_MAX_BODY) ? {{(DATA_W-MAX_W){1'b0}}, max_body_reg} : '0;
    assign max_body_bytes = max_body_reg;

endmodule

// ===== rtl/hrcd_parser.sv =====
// Header scan and chunk deframing, one byte per step.
module hrcd_parser import hrcd_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hrcd_word_t       word,
    input  logic [MAX_W-1:0] max_body_bytes,
    output hrcd_result_t     result
);

    localparam int SUM_W = (COUNT_WIDTH + 1 > MAX_W + 1) ? COUNT_WIDTH + 1 : MAX_W + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        PH_LINE1,
        PH_HDR_A,
        PH_HDR_B,
        PH_HDR,
        PH_DRAIN,
        PH_IDENT,
        PH_CSIZE,
        PH_CSIZE_CR,
        PH_CEXT,
        PH_CDATA,
        PH_CDATA_CR,
        PH_CDATA_LF
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [BYTE_W-1:0]       tail_reg [TAIL_DEPTH];
    logic [BYTE_W-1:0]       tail_cur [TAIL_DEPTH];
    logic                    status_ok_reg, status_ok_next;
    logic                    chunked_reg, chunked_next;
    logic [COUNT_WIDTH-1:0]  acc_reg, acc_next;
    logic                    digit_reg, digit_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [STATUS_W-1:0]     outcome_reg, outcome_next;

    logic [BYTE_W-1:0]       b;
    logic [BYTE_W-1:0]       prev;
    logic                    te_hit;
    logic                    ok_hit;
    logic                    hdr_end;
    logic [4:0]              hex;
    logic [COUNT_WIDTH+3:0]  acc_shift;
    logic [SUM_W-1:0]        line_sum;
    logic                    line_over;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic                    inc_over;
    logic [COUNT_WIDTH-1:0]  acc_dec;
    phase_t                  ld_phase;
    logic [STATUS_W-1:0]     ld_outcome;
    logic                    emit;
    logic [STATUS_W-1:0]     st;

    assign b    = word.raw_byte;
    assign prev = tail_reg[0];

    always_comb
    begin
        tail_cur[0] = b;
        for (int k = 1; k < TAIL_DEPTH; k++)
            tail_cur[k] = tail_reg[k-1];
    end

    always_comb
    begin
        te_hit = 1'b1;
        for (int k = 0; k < TAIL_DEPTH; k++)
            if (fold_case(tail_cur[k]) != TE_TEXT[8*k +: 8])
                te_hit = 1'b0;
        ok_hit = 1'b1;
        for (int k = 0; k < OK_LEN; k++)
            if (tail_cur[k] != OK_TEXT[8*k +: 8])
                ok_hit = 1'b0;
    end

    assign hdr_end = (b == CH_LF) && (tail_reg[0] == CH_CR) &&
                     (tail_reg[1] == CH_LF) && (tail_reg[2] == CH_CR);

    assign hex       = hex_value(b);
    assign acc_shift = {acc_reg, hex[3:0]};
    assign line_sum  = SUM_W'(count_reg) + SUM_W'(acc_reg);
    assign line_over = (line_sum > SUM_W'(max_body_bytes)) || line_sum[COUNT_WIDTH];
    assign count_inc = count_reg + 1'b1;
    assign inc_over  = SUM_W'(count_inc) > SUM_W'(max_body_bytes);
    assign acc_dec   = acc_reg - 1'b1;

    // end of a size line
    always_comb
    begin
        ld_phase   = PH_CDATA;
        ld_outcome = outcome_reg;
        if (!digit_reg)
        begin
            ld_phase   = PH_DRAIN;
            ld_outcome = ST_CHUNK_BAD;
        end
        else if (acc_reg == '0)
        begin
            ld_phase   = PH_DRAIN;
            ld_outcome = ST_OK;
        end
        else if (line_over)
        begin
            ld_phase   = PH_DRAIN;
            ld_outcome = ST_CHUNK_BAD;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        status_ok_next = status_ok_reg;
        chunked_next   = chunked_reg;
        acc_next       = acc_reg;
        digit_next     = digit_reg;
        count_next     = count_reg;
        outcome_next   = outcome_reg;
        emit           = 1'b0;

        case (phase_reg)
            PH_LINE1:
            begin
                if (te_hit)
                    chunked_next = 1'b1;
                if (ok_hit)
                    status_ok_next = 1'b1;
                if (b == CH_LF && prev == CH_CR)
                    phase_next = PH_HDR_A;
            end
            PH_HDR_A, PH_HDR_B, PH_HDR:
            begin
                if (te_hit)
                    chunked_next = 1'b1;
                if (hdr_end)
                begin
                    if (phase_reg == PH_HDR_B || !status_ok_reg)
                    begin
                        phase_next   = PH_DRAIN;
                        outcome_next = ST_NOT_200;
                    end
                    else if (chunked_reg)
                    begin
                        phase_next = PH_CSIZE;
                        acc_next   = '0;
                        digit_next = 1'b0;
                    end
                    else
                        phase_next = PH_IDENT;
                end
                else if (phase_reg == PH_HDR_A)
                    phase_next = PH_HDR_B;
                else
                    phase_next = PH_HDR;
            end
            PH_IDENT:
            begin
                emit = 1'b1;
                if (count_reg == COUNT_MAX)
                    outcome_next = ST_TOO_LARGE;
                else
                begin
                    count_next = count_inc;
                    if (inc_over)
                        outcome_next = ST_TOO_LARGE;
                end
            end
            PH_CSIZE:
            begin
                if (hex[4])
                begin
                    acc_next   = acc_shift[COUNT_WIDTH-1:0];
                    digit_next = 1'b1;
                    if (|acc_shift[COUNT_WIDTH+3:COUNT_WIDTH])
                    begin
                        phase_next   = PH_DRAIN;
                        outcome_next = ST_CHUNK_BAD;
                    end
                end
                else if (b == CH_SEMI)
                begin
                    if (digit_reg)
                        phase_next = PH_CEXT;
                    else
                    begin
                        phase_next   = PH_DRAIN;
                        outcome_next = ST_CHUNK_BAD;
                    end
                end
                else if (b == CH_CR)
                    phase_next = PH_CSIZE_CR;
                else
                begin
                    phase_next   = PH_DRAIN;
                    outcome_next = ST_CHUNK_BAD;
                end
            end
            PH_CSIZE_CR:
            begin
                if (b == CH_LF)
                begin
                    phase_next   = ld_phase;
                    outcome_next = ld_outcome;
                end
                else
                begin
                    phase_next   = PH_DRAIN;
                    outcome_next = ST_CHUNK_BAD;
                end
            end
            PH_CEXT:
            begin
                if (b == CH_LF && prev == CH_CR)
                begin
                    phase_next   = ld_phase;
                    outcome_next = ld_outcome;
                end
            end
            PH_CDATA:
            begin
                emit       = 1'b1;
                count_next = count_inc;
                acc_next   = acc_dec;
                if (acc_dec == '0)
                    phase_next = PH_CDATA_CR;
            end
            PH_CDATA_CR:
            begin
                if (b == CH_CR)
                    phase_next = PH_CDATA_LF;
                else
                begin
                    phase_next   = PH_DRAIN;
                    outcome_next = ST_CHUNK_BAD;
                end
            end
            PH_CDATA_LF:
            begin
                if (b == CH_LF)
                begin
                    phase_next = PH_CSIZE;
                    acc_next   = '0;
                    digit_next = 1'b0;
                end
                else
                begin
                    phase_next   = PH_DRAIN;
                    outcome_next = ST_CHUNK_BAD;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        st = ST_OK;
        if (word.end_of_response)
        begin
            if (phase_next inside {PH_LINE1, PH_HDR_A, PH_HDR_B, PH_HDR})
                st = ST_NO_HDR_END;
            else if (phase_next inside {PH_DRAIN, PH_IDENT})
                st = outcome_next;
            else
                st = ST_CHUNK_BAD;
        end
    end

    assign result.body_byte  = emit ? b : '0;
    assign result.body_valid = emit;
    assign result.done_res   = word.end_of_response;
    assign result.status     = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE1;
            status_ok_reg <= 1'b0;
            chunked_reg   <= 1'b0;
            acc_reg       <= '0;
            digit_reg     <= 1'b0;
            count_reg     <= '0;
            outcome_reg   <= ST_OK;
            for (int k = 0; k < TAIL_DEPTH; k++)
                tail_reg[k] <= '0;
        end
        else if (step)
        begin
            if (word.end_of_response)
            begin
                phase_reg     <= PH_LINE1;
                status_ok_reg <= 1'b0;
                chunked_reg   <= 1'b0;
                acc_reg       <= '0;
                digit_reg     <= 1'b0;
                count_reg     <= '0;
                outcome_reg   <= ST_OK;
                for (int k = 0; k < TAIL_DEPTH; k++)
                    tail_reg[k] <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                status_ok_reg <= status_ok_next;
                chunked_reg   <= chunked_next;
                acc_reg       <= acc_next;
                digit_reg     <= digit_next;
                count_reg     <= count_next;
                outcome_reg   <= outcome_next;
                for (int k = 0; k < TAIL_DEPTH; k++)
                    tail_reg[k] <= tail_cur[k];
            end
        end
    end

endmodule

// ===== rtl/http_response_chunked_deframer.sv =====
// Top level of the HTTP response chunked deframer.
//
//   channel   dir   word
//   in_ch     in    raw_byte, end_of_response
//   out_ch    out   body_byte, body_valid, done_res, status
//   apb       in    max_body_bytes at byte address 0
//
// One word in and one word out per cycle, sustained while the output is ready.
// A word passes through the input register, then the parser step into the result register.
// Parser state advances only when a word moves into the result register.
// A stalled output holds the result register; the input register still takes one word.
// rst_n clears all control state and sets max_body_bytes to 8388608.
module http_response_chunked_deframer import hrcd_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    hrcd_in_if.sink           in_ch,
    hrcd_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic             in_valid_reg;
    hrcd_word_t       in_word_reg;
    logic             out_valid_reg;
    hrcd_result_t     res_reg;
    hrcd_result_t     res_next;
    logic             step;
    logic             in_fire;
    logic [MAX_W-1:0] max_body_bytes;

    assign step         = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || step;
    assign in_fire      = in_ch.valid && in_ch.ready;

    hrcd_apb_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_body_bytes (max_body_bytes)
    );

    hrcd_parser #(.COUNT_WIDTH(COUNT_WIDTH)) u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .word           (in_word_reg),
        .max_body_bytes (max_body_bytes),
        .result         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg.raw_byte        <= in_ch.raw_byte;
            in_word_reg.end_of_response <= in_ch.end_of_response;
        end
        if (step)
            res_reg <= res_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.body_byte  = res_reg.body_byte;
    assign out_ch.body_valid = res_reg.body_valid;
    assign out_ch.done_res   = res_reg.done_res;
    assign out_ch.status     = res_reg.status;

endmodule

// ===== rtl/hrcd_port_checker.sv =====
// Port-level checks on the deframer output, bound to the top level.
`include "http_response_chunked_deframer_macros.svh"

module hrcd_port_checker import hrcd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [BYTE_W-1:0]   body_byte,
    input logic                body_valid,
    input logic                done_res,
    input logic [STATUS_W-1:0] status
);

    `HRCD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({body_byte, body_valid, done_res, status}))
    `HRCD_ASSERT_IMP(a_status_on_done, clk, rst_n, out_valid && !done_res, status == ST_OK)
    `HRCD_ASSERT_IMP(a_idle_byte_zero, clk, rst_n, out_valid && !body_valid, body_byte == '0)
    `HRCD_ASSERT_IMP(a_no_body_in_hdr, clk, rst_n, out_valid && done_res && status == ST_NO_HDR_END, !body_valid)

endmodule

bind http_response_chunked_deframer hrcd_port_checker u_port_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .body_byte  (out_ch.body_byte),
    .body_valid (out_ch.body_valid),
    .done_res   (out_ch.done_res),
    .status     (out_ch.status)
);

// ===== tb/sv/http_response_chunked_deframer_test.sv =====
// Self-checking testbench for the HTTP response chunked deframer.
`timescale 1ns / 100ps

module http_response_chunked_deframer_test import hrcd_pkg::*;;

    localparam int CNT_W = 25;
    localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W) - 64'd1;

    localparam string OK_HDR      = " 200 ~";
    localparam string CHUNKED_HDR = " 200 ~Transfer-Encoding: chunked~~";

    typedef enum logic [3:0] {
        P_STATUS_LINE,
        P_HDR_FIRST,
        P_HDR_SECOND,
        P_HDR_REST,
        P_DRAIN,
        P_IDENTITY,
        P_SIZE,
        P_SIZE_LF,
        P_EXT,
        P_DATA,
        P_DATA_CR,
        P_DATA_LF
    } parse_phase_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SPACE,
        FLAW_SIGN,
        FLAW_HEX_PREFIX,
        FLAW_NUL,
        FLAW_LONE_CR,
        FLAW_NO_DIGIT,
        FLAW_SEMI_FIRST,
        FLAW_HUGE,
        FLAW_BAD_CHAR,
        FLAW_NO_CRLF
    } flaw_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    hrcd_in_if  in_ch ();
    hrcd_out_if out_ch ();

    http_response_chunked_deframer #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hrcd_word_t   raw_pending[$];
    hrcd_result_t due_results[$];
    logic [7:0]   resp_bytes[$];
    int           queued_words;
    int           accepted_words;
    int           fail_count;
    logic         in_taken;
    logic         steady;

    // deframer state as seen by the predictor
    logic [MAX_W-1:0]        body_limit;
    parse_phase_t            parse;
    logic [8*TAIL_DEPTH-1:0] hdr_tail;
    logic                    saw_200;
    logic                    te_chunked;
    longint unsigned         size_acc;
    logic                    size_digits;
    longint unsigned         body_len;
    logic [STATUS_W-1:0]     outcome;

    function automatic void clear_parse();
        parse       = P_STATUS_LINE;
        hdr_tail    = '0;
        saw_200     = 1'b0;
        te_chunked  = 1'b0;
        size_acc    = 0;
        size_digits = 1'b0;
        body_len    = 0;
        outcome     = ST_OK;
    endfunction

    function automatic logic te_in_tail();
        logic [7:0] c;
        logic       hit;
        hit = 1'b1;
        for (int k = 0; k < TAIL_DEPTH; k++)
        begin
            c = hdr_tail[8*k +: 8];
            if (c >= 8'h41 && c <= 8'h5A)
                c = c + 8'h20;
            if (c != TE_TEXT[8*k +: 8])
                hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - 8'h30);
        if (c >= "a" && c <= "f")
            return int'(c - 8'h57);
        if (c >= "A" && c <= "F")
            return int'(c - 8'h37);
        return -1;
    endfunction

    function automatic void chunk_fail();
        parse   = P_DRAIN;
        outcome = ST_CHUNK_BAD;
    endfunction

    function automatic void size_line_end();
        if (!size_digits)
            chunk_fail();
        else if (size_acc == 0)
        begin
            parse   = P_DRAIN;
            outcome = ST_OK;
        end
        else if (body_len + size_acc > body_limit || body_len + size_acc > COUNT_MAX)
            chunk_fail();
        else
            parse = P_DATA;
    endfunction

    function automatic hrcd_result_t predict_word(input logic [7:0] b, input logic last);
        hrcd_result_t r;
        logic [7:0]   prev;
        int           h;
        r        = '0;
        prev     = hdr_tail[7:0];
        hdr_tail = {hdr_tail[8*TAIL_DEPTH-9:0], b};
        case (parse)
            P_STATUS_LINE, P_HDR_FIRST, P_HDR_SECOND, P_HDR_REST:
            begin
                if (te_in_tail())
                    te_chunked = 1'b1;
                if (parse == P_STATUS_LINE)
                begin
                    if (hdr_tail[8*OK_LEN-1:0] == OK_TEXT)
                        saw_200 = 1'b1;
                    if (b == CH_LF && prev == CH_CR)
                        parse = P_HDR_FIRST;
                end
                else if (hdr_tail[31:0] == {CH_CR, CH_LF, CH_CR, CH_LF})
                begin
                    // a blank line right after the status line counts as a bad header
                    if (parse == P_HDR_SECOND || !saw_200)
                    begin
                        parse   = P_DRAIN;
                        outcome = ST_NOT_200;
                    end
                    else if (te_chunked)
                    begin
                        parse       = P_SIZE;
                        size_acc    = 0;
                        size_digits = 1'b0;
                    end
                    else
                        parse = P_IDENTITY;
                end
                else if (parse == P_HDR_FIRST)
                    parse = P_HDR_SECOND;
                else
                    parse = P_HDR_REST;
            end
            P_IDENTITY:
            begin
                r.body_valid = 1'b1;
                if (body_len >= COUNT_MAX)
                    outcome = ST_TOO_LARGE;
                else
                begin
                    body_len++;
                    if (body_len > body_limit)
                        outcome = ST_TOO_LARGE;
                end
            end
            P_SIZE:
            begin
                h = hex_nibble(b);
                if (h >= 0)
                begin
                    size_acc    = size_acc * 16 + h;
                    size_digits = 1'b1;
                    if (size_acc > COUNT_MAX)
                        chunk_fail();
                end
                else if (b == CH_SEMI)
                begin
                    if (size_digits)
                        parse = P_EXT;
                    else
                        chunk_fail();
                end
                else if (b == CH_CR)
                    parse = P_SIZE_LF;
                else
                    chunk_fail();
            end
            P_SIZE_LF:
            begin
                if (b == CH_LF)
                    size_line_end();
                else
                    chunk_fail();
            end
            P_EXT:
            begin
                if (b == CH_LF && prev == CH_CR)
                    size_line_end();
            end
            P_DATA:
            begin
                r.body_valid = 1'b1;
                body_len++;
                size_acc--;
                if (size_acc == 0)
                    parse = P_DATA_CR;
            end
            P_DATA_CR:
            begin
                if (b == CH_CR)
                    parse = P_DATA_LF;
                else
                    chunk_fail();
            end
            P_DATA_LF:
            begin
                if (b == CH_LF)
                begin
                    parse       = P_SIZE;
                    size_acc    = 0;
                    size_digits = 1'b0;
                end
                else
                    chunk_fail();
            end
            default:
            begin
            end
        endcase
        if (r.body_valid)
            r.body_byte = b;
        r.done_res = last;
        if (last)
        begin
            if (parse <= P_HDR_REST)
                r.status = ST_NO_HDR_END;
            else if (parse == P_DRAIN || parse == P_IDENTITY)
                r.status = outcome;
            else
                r.status = ST_CHUNK_BAD;
            clear_parse();
        end
        return r;
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        resp_bytes.insert(resp_bytes.size(), c);
    endfunction

    // response text: '~' stands for CR LF
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == "~")
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            else
                add_byte(s[i]);
        end
    endfunction

    function automatic void add_random(input int n, input logic [7:0] lo, input logic [7:0] hi);
        repeat (n)
            add_byte(8'($urandom_range(hi, lo)));
    endfunction

    function automatic void ship_response();
        hrcd_word_t w;
        for (int i = 0; i < resp_bytes.size(); i++)
        begin
            w.raw_byte        = resp_bytes[i];
            w.end_of_response = (i == resp_bytes.size() - 1);
            raw_pending.insert(raw_pending.size(), w);
            queued_words++;
        end
        resp_bytes.delete();
    endfunction

    function automatic void send(input string s);
        add_text(s);
        ship_response();
    endfunction

    function automatic void add_te_line(input logic corrupt);
        logic [7:0] c;
        int         spot;
        spot = corrupt ? int'($urandom_range(TAIL_DEPTH - 1, 0)) : -1;
        for (int k = TAIL_DEPTH - 1; k >= 0; k--)
        begin
            c = TE_TEXT[8*k +: 8];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1, 0) == 1)
                c = c - 8'h20;
            if (k == spot)
                c = "*";
            add_byte(c);
        end
        add_text("~");
    endfunction

    function automatic void add_size_line(input int unsigned size, input flaw_t flaw);
        int         nib;
        logic [3:0] d;
        case (flaw)
            FLAW_SPACE:      add_text(" ");
            FLAW_SIGN:       add_text("+");
            FLAW_HEX_PREFIX: add_text("0x");
            FLAW_NUL:        add_byte(8'h00);
            default:
            begin
            end
        endcase
        if (flaw == FLAW_SEMI_FIRST)
            add_text(";");
        else if (flaw == FLAW_HUGE)
            add_text("2000000");
        else if (flaw != FLAW_NO_DIGIT)
        begin
            repeat ($urandom_range(2, 0))
                add_text("0");
            nib = 7;
            while (nib > 0 && size[4*nib +: 4] == 4'h0)
                nib--;
            for (; nib >= 0; nib--)
            begin
                d = size[4*nib +: 4];
                if (d < 4'd10)
                    add_byte(8'h30 + d);
                else
                    add_byte((($urandom_range(1, 0) == 1) ? 8'h61 : 8'h41) + d - 8'd10);
            end
        end
        if (flaw == FLAW_LONE_CR)
        begin
            add_byte(CH_CR);
            add_text("5");
        end
        if (flaw == FLAW_BAD_CHAR)
            add_text("g");
        if (flaw == FLAW_NONE && $urandom_range(4, 0) == 0)
            add_text(";ext=v");
        add_text("~");
    endfunction

    function automatic void queue_random_response();
        int          nchunks;
        int          flaw_at;
        int          cut;
        int unsigned size;
        logic        chunked_body;
        flaw_t       flaw;
        if ($urandom_range(19, 0) == 0)
            add_random($urandom_range(24, 1), 8'h00, 8'hFF);
        else
        begin
            case ($urandom_range(9, 0))
                0: add_text("HTTP/1.1 404 Not Found");
                1: add_text("HTTP/1.1 200");
                2: add_text(" 200 ");
                3:
                begin
                    add_random(3, 8'h20, 8'h7D);
                    add_text(" 200 x");
                end
                default: add_text("HTTP/1.1 200 OK");
            endcase
            add_text("~");
            repeat ($urandom_range(2, 0))
            begin
                add_random($urandom_range(10, 1), 8'h20, 8'h7D);
                add_text("~");
            end
            chunked_body = 1'($urandom_range(1, 0));
            if (chunked_body)
                add_te_line($urandom_range(9, 0) == 0);
            add_text("~");
            if (!chunked_body)
                add_random($urandom_range(30, 0), 8'h00, 8'hFF);
            else
            begin
                nchunks = $urandom_range(3, 0);
                flaw    = ($urandom_range(3, 0) == 0) ? flaw_t'($urandom_range(10, 1)) : FLAW_NONE;
                flaw_at = $urandom_range(nchunks, 0);
                for (int k = 0; k <= nchunks; k++)
                begin
                    if (k == nchunks)
                        size = 0;
                    else if ($urandom_range(11, 0) == 0)
                        size = $urandom_range(24'hFFFFFF, 13);
                    else
                        size = $urandom_range(12, 1);
                    add_size_line(size, (k == flaw_at) ? flaw : FLAW_NONE);
                    if (k < nchunks)
                    begin
                        add_random((size > 20) ? 20 : int'(size), 8'h00, 8'hFF);
                        add_text((flaw == FLAW_NO_CRLF && k == flaw_at) ? "X~" : "~");
                    end
                end
                add_random($urandom_range(4, 0), 8'h00, 8'hFF);
            end
        end
        if ($urandom_range(7, 0) == 0)
        begin
            cut        = $urandom_range(resp_bytes.size() - 1, 0);
            resp_bytes = resp_bytes[0:cut];
        end
        ship_response();
    endfunction

    task automatic queue_random(input int n);
        int start;
        @(posedge clk);
        start = queued_words;
        while (queued_words - start < n)
            queue_random_response();
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (accepted_words != queued_words || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_body_limit(input logic [DATA_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_BODY;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        body_limit = v[MAX_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[MAX_W-1:0] !== body_limit)
        begin
            $error("max_body_bytes: expected %0d, got %0d", body_limit, prdata[MAX_W-1:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver: presents raw bytes and the output ready
    always @(negedge clk)
    begin
        hrcd_word_t w;
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= steady || ($urandom_range(99, 0) >= 27);
            if (!in_ch.valid || in_taken)
            begin
                if (raw_pending.size() != 0 && (steady || $urandom_range(99, 0) >= 27))
                begin
                    w = raw_pending.pop_front();
                    in_ch.valid           <= 1'b1;
                    in_ch.raw_byte        <= w.raw_byte;
                    in_ch.end_of_response <= w.end_of_response;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks results first, then predicts for the accepted byte
    always @(posedge clk)
    begin
        hrcd_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("body_byte", 32'(want.body_byte), 32'(out_ch.body_byte));
                    check_field("body_valid", 32'(want.body_valid), 32'(out_ch.body_valid));
                    check_field("done_res", 32'(want.done_res), 32'(out_ch.done_res));
                    check_field("status", 32'(want.status), 32'(out_ch.status));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                due_results.insert(due_results.size(),
                                   predict_word(in_ch.raw_byte, in_ch.end_of_response));
                accepted_words++;
            end
        end
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
    end

    initial
    begin
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.raw_byte        = '0;
        in_ch.end_of_response = 1'b0;
        out_ch.ready          = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = REG_MAX_BODY;
        pwdata                = '0;
        steady                = 1'b0;
        in_taken              = 1'b0;
        queued_words          = 0;
        accepted_words        = 0;
        fail_count            = 0;
        body_limit            = MAX_BODY_RESET;
        clear_parse();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed responses under the reset limit
        send("HTTP/1.1 200 OK~Content-Type: text~~hello");
        send("HTTP/1.1 200 OK~Transfer-ENCODING: ChUnKeD~~4;ext=1~Wiki~a~0123456789~0~~");
        send("HTTP/1.1 404 Not Found~A: b~~");
        send(" 200 ~~");
        send("HTTP/1.1 200 OK~abc");
        send({CHUNKED_HDR, " 5~hello~0~~"});
        send({CHUNKED_HDR, "+5~hello~0~~"});
        send({CHUNKED_HDR, "0x5~hello~0~~"});
        add_text(CHUNKED_HDR);
        add_byte(8'h00);
        send("5~hello~0~~");
        add_text({CHUNKED_HDR, "5"});
        add_byte(CH_CR);
        send("5~hello~0~~");
        send({CHUNKED_HDR, "2000000~"});
        send({CHUNKED_HDR, "5~hel"});
        send({CHUNKED_HDR, "3~abcX~0~~"});
        send({CHUNKED_HDR, "~"});
        send({CHUNKED_HDR, ";x~"});
        add_text({OK_HDR, "A: b~~"});
        add_byte(8'h00);
        add_byte(8'hFF);
        ship_response();
        add_byte(8'hFF);
        ship_response();
        drain();

        write_body_limit({8'($urandom_range(255, 0)), 24'h000000});
        @(posedge clk);
        send({OK_HDR, "A: b~~x"});
        send({OK_HDR, "A: b~~"});
        send({CHUNKED_HDR, "1~a~0~~"});
        send({CHUNKED_HDR, "0~~"});
        queue_random(10);
        drain();

        steady = 1'b1;
        write_body_limit(32'h00FF_FFFF);
        queue_random(80);
        drain();
        steady = 1'b0;

        write_body_limit($urandom_range(40, 8));
        queue_random(10);
        drain();

        write_body_limit($urandom);
        queue_random(10);
        drain();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
